// ===== rtl/core/highest_polygon_containing_point_assert.svh =====
// Assertion macros shared by the polygon query block.
// Needs clk and arst_n in the including scope.
`ifndef HIGHEST_POLYGON_CONTAINING_POINT_ASSERT_SVH
`define HIGHEST_POLYGON_CONTAINING_POINT_ASSERT_SVH

// checked only outside reset
`define HPCP_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define HPCP_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/hpcp_pkg.sv =====
`timescale 1ns / 1ps
// Package for the highest polygon query block: item modes, register
// indexes and sequencer states. No dependencies.
package hpcp_pkg;

	localparam logic [1:0] MODE_VERTEX = 2'd0;
	localparam logic [1:0] MODE_BOX    = 2'd1;
	localparam logic [1:0] MODE_QUERY  = 2'd2;

	localparam logic REG_WALKBOX_COUNT = 1'b0;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_BOX_RD,
		ST_BOX_CHK,
		ST_LAST,
		ST_EDGE,
		ST_MUL2,
		ST_CMP,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/core/hpcp_mul.sv =====
`timescale 1ns / 1ps
// Shared signed multiplier with a registered product, used for both
// cross products of each edge test. No package dependencies.
module hpcp_mul #(
	parameter int W = 29
) (
	input  logic                  clk,
	input  logic signed [W-1:0]   a,
	input  logic signed [W-1:0]   b,
	output logic signed [2*W-1:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= (2*W)'(a) * (2*W)'(b);
	end

endmodule

// ===== rtl/core/highest_polygon_containing_point.sv =====
`timescale 1ns / 1ps
// Highest polygon containing a point: polygon store plus query sequencer.
// Uses hpcp_pkg, hpcp_mul and highest_polygon_containing_point_assert.svh.
// Store writes (modes 0, 1) complete while idle; busy stays low.
// A query examines polygons one at a time and tests each edge in turn; only
// edges spanning the query z use the shared multiplier, and vertices come
// through the single vertex memory read port. Result strobe done lasts one cycle.
// Reset clears the sequencer state and walkbox_count only; stores are undefined.
module highest_polygon_containing_point
	import hpcp_pkg::*;
#(
	parameter int MAX_BOXES    = 128,
	parameter int MAX_VERTICES = 8,
	parameter int COORD_BITS   = 28
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [2:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   mode,
	input  logic [6:0]                   box_index,
	input  logic [2:0]                   vertex_index,
	input  logic signed [COORD_BITS-1:0] coord_x,
	input  logic signed [COORD_BITS-1:0] coord_z,
	input  logic signed [COORD_BITS-1:0] altitude_in,
	input  logic [3:0]                   vertex_count_in,
	output logic                         done,
	output logic                         inside_any,
	output logic [6:0]                   best_box,
	output logic signed [COORD_BITS-1:0] best_altitude
);

	localparam int CW     = COORD_BITS;
	localparam int DW     = CW + 1;
	localparam int PW     = 2 * DW;
	localparam int VDEPTH = MAX_BOXES * MAX_VERTICES;
	localparam int ADDR_W = $clog2(VDEPTH);
	localparam int BOX_W  = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int VTX_W  = $clog2(MAX_VERTICES);
	localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
	localparam int LW     = 11;

	state_t state_q, state_d;

	logic [7:0] wbc_q;

	// stores
	logic [2*CW-1:0]    vmem [VDEPTH];
	logic [CW+CNT_W-1:0] bmem [MAX_BOXES];
	logic [2*CW-1:0]    vrd_q;
	logic [CW+CNT_W-1:0] brd_q;

	// sequencer datapath
	logic signed [CW-1:0] qx_q, qz_q, lx_q, lz_q, alt_q, best_alt_q;
	logic [LW-1:0]        box_q, limit_q;
	logic [CNT_W-1:0]     v_q, n_q;
	logic                 parity_q, found_q, dzpos_q;
	logic [LW-1:0]        best_q;
	logic signed [PW-1:0] p1_q, mul_p;
	logic signed [DW-1:0] mul_a, mul_b;

	logic                 accept;
	logic [LW-1:0]        wbox_ext, box_next, best_ext;
	logic [4:0]           cnt_ext, vtx_ext;
	logic [CNT_W-1:0]     cnt_sat, v_next, vsel;
	logic [VTX_W-1:0]     wvtx;
	logic [ADDR_W-1:0]    waddr, raddr;
	logic                 vrd_en, cond, toggle, adv, box_end, par_new;
	logic signed [CW-1:0] cx, cz, rd_alt;
	logic [CNT_W-1:0]     rd_cnt;

	assign accept  = start && !busy;
	assign busy    = (state_q != ST_IDLE);
	assign pready  = 1'b1;
	assign prdata  = (paddr[2] == REG_WALKBOX_COUNT) ? {24'b0, wbc_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wbc_q <= '0;
		end else if (psel && penable && pwrite && paddr[2] == REG_WALKBOX_COUNT) begin
			wbc_q <= pwdata[7:0];
		end
	end

	// write addressing
	assign wbox_ext = LW'(box_index);
	assign vtx_ext  = 5'(vertex_index);
	assign wvtx     = vtx_ext[VTX_W-1:0];
	assign cnt_ext  = 5'(vertex_count_in);
	assign cnt_sat  = (cnt_ext > 5'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : CNT_W'(cnt_ext);
	assign waddr    = ADDR_W'(wbox_ext[BOX_W-1:0]) * ADDR_W'(MAX_VERTICES) + ADDR_W'(wvtx);

	always_ff @(posedge clk) begin
		if (accept && mode == MODE_VERTEX && wbox_ext < LW'(MAX_BOXES)
				&& vtx_ext < 5'(MAX_VERTICES)) begin
			vmem[waddr] <= {coord_z, coord_x};
		end
		if (accept && mode == MODE_BOX && wbox_ext < LW'(MAX_BOXES)) begin
			bmem[wbox_ext[BOX_W-1:0]] <= {cnt_sat, altitude_in};
		end
	end

	// box store read: polygon 0 while idle, else the current polygon
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			brd_q <= bmem[0];
		end else begin
			brd_q <= bmem[box_q[BOX_W-1:0]];
		end
		if (vrd_en) begin
			vrd_q <= vmem[raddr];
		end
	end

	assign rd_alt = brd_q[CW-1:0];
	assign rd_cnt = brd_q[CW+CNT_W-1:CW];
	assign cx     = vrd_q[CW-1:0];
	assign cz     = vrd_q[2*CW-1:CW];
	assign raddr  = ADDR_W'(box_q[BOX_W-1:0]) * ADDR_W'(MAX_VERTICES) + ADDR_W'(vsel);

	// edge straddles the query z
	assign cond = (cz > qz_q && qz_q >= lz_q) || (cz <= qz_q && qz_q < lz_q);

	always_comb begin
		if (state_q == ST_EDGE) begin
			mul_a = DW'(qx_q) - DW'(cx);
			mul_b = DW'(lz_q) - DW'(cz);
		end else begin
			mul_a = DW'(lx_q) - DW'(cx);
			mul_b = DW'(qz_q) - DW'(cz);
		end
	end

	hpcp_mul #(.W(DW)) u_mul (
		.clk(clk),
		.a  (mul_a),
		.b  (mul_b),
		.p_q(mul_p)
	);

	assign toggle   = dzpos_q ? (p1_q < mul_p) : (p1_q > mul_p);
	assign v_next   = v_q + CNT_W'(1);
	assign box_next = box_q + LW'(1);
	assign box_end  = (v_next == n_q);
	assign par_new  = parity_q ^ ((state_q == ST_CMP) && toggle);
	assign adv      = (state_q == ST_EDGE && !cond) || (state_q == ST_CMP);

	always_comb begin
		state_d = state_q;
		vrd_en  = 1'b0;
		vsel    = v_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && mode == MODE_QUERY) begin
					state_d = ST_INIT;
				end
			end
			ST_INIT: begin
				state_d = (limit_q == '0) ? ST_DONE : ST_BOX_RD;
			end
			ST_BOX_RD: begin
				state_d = ST_BOX_CHK;
			end
			ST_BOX_CHK: begin
				if (rd_cnt == '0) begin
					state_d = (box_next == limit_q) ? ST_DONE : ST_BOX_RD;
				end else begin
					vrd_en  = 1'b1;
					vsel    = rd_cnt - CNT_W'(1);
					state_d = ST_LAST;
				end
			end
			ST_LAST: begin
				vrd_en  = 1'b1;
				vsel    = '0;
				state_d = ST_EDGE;
			end
			ST_EDGE, ST_CMP: begin
				if (state_q == ST_EDGE && cond) begin
					state_d = ST_MUL2;
				end else if (box_end) begin
					state_d = (box_next == limit_q) ? ST_DONE : ST_BOX_RD;
				end else begin
					vrd_en  = 1'b1;
					vsel    = v_next;
					state_d = ST_EDGE;
				end
			end
			ST_MUL2: begin
				state_d = ST_CMP;
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				qx_q    <= coord_x;
				qz_q    <= coord_z;
				limit_q <= (LW'(wbc_q) > LW'(MAX_BOXES)) ? LW'(MAX_BOXES) : LW'(wbc_q);
			end
			ST_INIT: begin
				best_alt_q <= rd_alt;
				best_q     <= '0;
				found_q    <= 1'b0;
				box_q      <= '0;
			end
			ST_BOX_CHK: begin
				alt_q <= rd_alt;
				n_q   <= rd_cnt;
				if (rd_cnt == '0) begin
					box_q <= box_next;
				end
			end
			ST_LAST: begin
				lx_q     <= cx;
				lz_q     <= cz;
				v_q      <= '0;
				parity_q <= 1'b0;
			end
			ST_EDGE: begin
				dzpos_q <= (lz_q > cz);
			end
			ST_MUL2: begin
				p1_q <= mul_p;
			end
			default: begin
			end
		endcase
		if (adv) begin
			lx_q     <= cx;
			lz_q     <= cz;
			v_q      <= v_next;
			parity_q <= par_new;
			if (box_end) begin
				box_q <= box_next;
				if (par_new && (!found_q || alt_q > best_alt_q)) begin
					found_q    <= 1'b1;
					best_q     <= box_q;
					best_alt_q <= alt_q;
				end
			end
		end
	end

	assign best_ext      = best_q;
	assign done          = (state_q == ST_DONE);
	assign inside_any    = found_q;
	assign best_box      = best_ext[6:0];
	assign best_altitude = best_alt_q;

`include "highest_polygon_containing_point_assert.svh"

	`HPCP_ASSERT(a_done_one_cycle, done |=> !done && !busy, "result strobe longer than one cycle")
	`HPCP_ASSERT(a_query_busy, (accept && mode == MODE_QUERY) |=> busy, "query accepted but not busy")
	`HPCP_ASSERT(a_none_box0, (done && !inside_any) |-> best_q == '0, "no match but nonzero polygon")
	`HPCP_ASSERT_ALWAYS(a_edge_in_range, (state_q == ST_EDGE) |-> (v_q < n_q), "vertex index past count")

endmodule
